// ===== rtl/core/brjq_pkg.sv =====
// ----------------------------------------------------------------------------
// brjq_pkg
// Shared types and constants for the blocked / ready job queue block.
// ----------------------------------------------------------------------------
package brjq_pkg;

  localparam int LIST_DEPTH_DEF = 16;
  localparam int JOB_WIDTH_DEF  = 16;

  // fixed field widths of the stream words
  localparam int CMD_W    = 2;
  localparam int JOB_ID_W = 16;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_BLOCK     = 2'd0,
    CMD_IO_FINISH = 2'd1,
    CMD_UNBLOCK   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_BLOCKED_FULL = 3'd1,
    ST_READY_FULL   = 3'd2,
    ST_BAD_POSITION = 3'd3,
    ST_READY_EMPTY  = 3'd4
  } status_t;

  // per-cell control: load a new job, or take the right neighbor's entry
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/brjq_cell.sv =====
// ----------------------------------------------------------------------------
// brjq_cell
// One list slot: loads a new job or takes the entry of its right neighbor.
// ----------------------------------------------------------------------------
module brjq_cell #(
  parameter int JOB_WIDTH = brjq_pkg::JOB_WIDTH_DEF
) (
  input  logic                  clk,
  input  brjq_pkg::cell_ctrl_t  ctrl,
  input  logic [JOB_WIDTH-1:0]  new_data,
  input  logic [JOB_WIDTH-1:0]  nbr_data,
  output logic [JOB_WIDTH-1:0]  data
);
  import brjq_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= new_data;
    end else if (ctrl.shift) begin
      data <= nbr_data;
    end
  end

endmodule

// ===== rtl/core/blocked_ready_job_queues_unit.sv =====
// ----------------------------------------------------------------------------
// blocked_ready_job_queues_unit
// Blocked list and ready queue of jobs, each a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one command word per handshake. s_tuser carries the
//   command (block, io finished, unblock); s_tdata carries the job id and the
//   blocked-list position.
//   Master channel m_*: exactly one result word per command, with the popped
//   job, status and both list counts after the command.
//   The result word is registered and appears in the cycle after the command is taken.
//   Throughput: one command per cycle while m_tready is high. Every cell
//   of a list compacts in parallel with its neighbor in the same cycle,
//   and the output register is refilled while its word is being taken.
//   When m_tready is low and a result word waits, s_tready drops and the
//   lists hold until the word is taken.
//   Reset clears both counts and the output valid; list contents are left
//   as they are, since no entry beyond a count is ever read.
// ----------------------------------------------------------------------------
module blocked_ready_job_queues_unit #(
  parameter int LIST_DEPTH = brjq_pkg::LIST_DEPTH_DEF,
  parameter int JOB_WIDTH  = brjq_pkg::JOB_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [brjq_pkg::S_DATA_W-1:0] s_tdata,  // job_id[15:0], position[19:16], zero pad
  input  logic [brjq_pkg::CMD_W-1:0]    s_tuser,  // command[1:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [brjq_pkg::M_DATA_W-1:0] m_tdata,  // job_out[15:0], status[18:16],
                                                  // blocked_count[23:19],
                                                  // ready_count[28:24], zero pad
  output logic                          m_tuser   // job_valid
);
  import brjq_pkg::*;

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W = $clog2(LIST_DEPTH);
  localparam int CW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic                 accept;
  cmd_t                 cmd;
  logic [JOB_WIDTH-1:0] job_in;
  logic [CW-1:0]        pos_ext;
  logic                 push_ok;
  logic                 move_ok;
  logic                 pop_ok;
  status_t              status_next;
  logic [CNT_W-1:0]     blocked_total;
  logic [CNT_W-1:0]     ready_total;
  logic [CNT_W-1:0]     blocked_total_next;
  logic [CNT_W-1:0]     ready_total_next;
  logic [JOB_WIDTH-1:0] picked;
  logic [JOB_WIDTH-1:0] blk_data [LIST_DEPTH];
  logic [JOB_WIDTH-1:0] rdy_data [LIST_DEPTH];

  logic [JOB_ID_W-1:0]  out_job;
  logic                 out_job_valid;
  status_t              out_status;
  logic [COUNT_W-1:0]   out_bcnt;
  logic [COUNT_W-1:0]   out_rcnt;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign cmd      = cmd_t'(s_tuser);
  assign job_in   = JOB_WIDTH'(s_tdata[JOB_ID_W-1:0]);
  assign pos_ext  = CW'(s_tdata[JOB_ID_W +: POS_W]);
  assign picked   = blk_data[pos_ext[IDX_W-1:0]];

  always_comb begin
    push_ok            = 1'b0;
    move_ok            = 1'b0;
    pop_ok             = 1'b0;
    status_next        = ST_OK;
    blocked_total_next = blocked_total;
    ready_total_next   = ready_total;
    case (cmd)
      CMD_BLOCK: begin
        if (blocked_total == CNT_W'(LIST_DEPTH)) begin
          status_next = ST_BLOCKED_FULL;
        end else begin
          push_ok            = 1'b1;
          blocked_total_next = blocked_total + 1'b1;
        end
      end
      CMD_IO_FINISH: begin
        // position check first; it also covers a position past the depth
        if (pos_ext >= CW'(blocked_total)) begin
          status_next = ST_BAD_POSITION;
        end else if (ready_total == CNT_W'(LIST_DEPTH)) begin
          status_next = ST_READY_FULL;
        end else begin
          move_ok            = 1'b1;
          blocked_total_next = blocked_total - 1'b1;
          ready_total_next   = ready_total + 1'b1;
        end
      end
      CMD_UNBLOCK: begin
        if (ready_total == '0) begin
          status_next = ST_READY_EMPTY;
        end else begin
          pop_ok           = 1'b1;
          ready_total_next = ready_total - 1'b1;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // cell rows: blocked list closes gaps from position up, ready queue pops at head
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    cell_ctrl_t           blk_ctrl;
    cell_ctrl_t           rdy_ctrl;
    logic [JOB_WIDTH-1:0] blk_nbr;
    logic [JOB_WIDTH-1:0] rdy_nbr;

    assign blk_ctrl.load  = accept && push_ok && (blocked_total == CNT_W'(i));
    assign blk_ctrl.shift = accept && move_ok && (CW'(i) >= pos_ext);
    assign rdy_ctrl.load  = accept && move_ok && (ready_total == CNT_W'(i));
    assign rdy_ctrl.shift = accept && pop_ok;

    if (i < LIST_DEPTH - 1) begin : g_mid
      assign blk_nbr = blk_data[i+1];
      assign rdy_nbr = rdy_data[i+1];
    end else begin : g_end
      assign blk_nbr = blk_data[i];
      assign rdy_nbr = rdy_data[i];
    end

    brjq_cell #(.JOB_WIDTH(JOB_WIDTH)) u_blk (
      .clk      (clk),
      .ctrl     (blk_ctrl),
      .new_data (job_in),
      .nbr_data (blk_nbr),
      .data     (blk_data[i])
    );

    brjq_cell #(.JOB_WIDTH(JOB_WIDTH)) u_rdy (
      .clk      (clk),
      .ctrl     (rdy_ctrl),
      .new_data (picked),
      .nbr_data (rdy_nbr),
      .data     (rdy_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocked_total <= '0;
      ready_total   <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (accept) begin
        blocked_total <= blocked_total_next;
        ready_total   <= ready_total_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result word, loaded whenever a command is taken
  always_ff @(posedge clk) begin
    if (accept) begin
      out_job       <= pop_ok ? JOB_ID_W'(rdy_data[0]) : '0;
      out_job_valid <= pop_ok;
      out_status    <= status_next;
      out_bcnt      <= COUNT_W'(blocked_total_next);
      out_rcnt      <= COUNT_W'(ready_total_next);
    end
  end

  assign m_tdata = {{(M_DATA_W - JOB_ID_W - STATUS_W - 2 * COUNT_W){1'b0}},
                    out_rcnt, out_bcnt, out_status, out_job};
  assign m_tuser = out_job_valid;

endmodule

// ===== rtl/core/brjq_checker.sv =====
// ----------------------------------------------------------------------------
// brjq_checker
// Port-level checks for the blocked / ready job queue block.
// ----------------------------------------------------------------------------
module brjq_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [brjq_pkg::M_DATA_W-1:0] m_tdata,
  input logic                          m_tuser
);
  import brjq_pkg::*;

  // a waiting result word stays up until taken
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result word dropped while stalled");

  // a popped job always comes with ok status
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[18:16] == ST_OK)
    else $error("popped job with error status");

  // no popped job means job field is zero
  a_job_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[15:0] == '0)
    else $error("job field set without a popped job");

  // every taken command yields a result word in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("command taken without a result word");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word valid after reset");

endmodule

bind blocked_ready_job_queues_unit brjq_checker u_brjq_checker (.*);
